### rtl/core/ngh_pkg.sv
// shared types, constants and head tables for the n-gram hash row id block
package ngh_pkg;

  localparam int HEAD_W  = 4;
  localparam int ROW_W   = 29;
  localparam int PRIME_W = 25;
  localparam int TOK_W   = 32;
  localparam int HASH_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 40;

  localparam logic [63:0] MUL_UNI = 64'd23703573157769;
  localparam logic [63:0] MUL_BI  = 64'd20109073645365;
  localparam logic [63:0] MUL_TRI = 64'd8052911324071;

  // constants split into a low word and the few high bits above it
  localparam logic [31:0] UNI_LO = MUL_UNI[31:0];
  localparam logic [12:0] UNI_HI = MUL_UNI[44:32];
  localparam logic [31:0] BI_LO  = MUL_BI[31:0];
  localparam logic [12:0] BI_HI  = MUL_BI[44:32];
  localparam logic [31:0] TRI_LO = MUL_TRI[31:0];
  localparam logic [12:0] TRI_HI = MUL_TRI[44:32];

  typedef struct packed {
    logic signed [TOK_W-1:0] cur;
    logic signed [TOK_W-1:0] h1;
    logic signed [TOK_W-1:0] h2;
  } entry_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [HEAD_W-1:0] head;
    logic              last;
  } mod_req_t;

  typedef logic [15:0][PRIME_W-1:0] prime_tab_t;
  typedef logic [15:0][RECIP_W-1:0] recip_tab_t;

  function automatic logic [PRIME_W-1:0] head_prime(input logic [HEAD_W-1:0] h);
    logic [PRIME_W-1:0] p;
    case (h)
      4'd0:    p = 25'd20000003;
      4'd1:    p = 25'd20000023;
      4'd2:    p = 25'd20000033;
      4'd3:    p = 25'd20000047;
      4'd4:    p = 25'd20000059;
      4'd5:    p = 25'd20000063;
      4'd6:    p = 25'd20000069;
      4'd7:    p = 25'd20000077;
      4'd8:    p = 25'd20000081;
      4'd9:    p = 25'd20000093;
      4'd10:   p = 25'd20000107;
      4'd11:   p = 25'd20000147;
      4'd12:   p = 25'd20000153;
      4'd13:   p = 25'd20000159;
      4'd14:   p = 25'd20000161;
      4'd15:   p = 25'd20000171;
      default: p = 25'd20000003;
    endcase
    return p;
  endfunction

  function automatic logic [ROW_W-1:0] head_base(input logic [HEAD_W-1:0] h);
    logic [ROW_W-1:0] b;
    case (h)
      4'd0:    b = 29'd0;
      4'd1:    b = 29'd20000003;
      4'd2:    b = 29'd40000026;
      4'd3:    b = 29'd60000059;
      4'd4:    b = 29'd80000106;
      4'd5:    b = 29'd100000165;
      4'd6:    b = 29'd120000228;
      4'd7:    b = 29'd140000297;
      4'd8:    b = 29'd160000374;
      4'd9:    b = 29'd180000455;
      4'd10:   b = 29'd200000548;
      4'd11:   b = 29'd220000655;
      4'd12:   b = 29'd240000802;
      4'd13:   b = 29'd260000955;
      4'd14:   b = 29'd280001114;
      4'd15:   b = 29'd300001275;
      default: b = 29'd0;
    endcase
    return b;
  endfunction

  // 2^e mod prime for every head, evaluated at elaboration
  function automatic prime_tab_t pow2_mod_tab(input int unsigned e);
    prime_tab_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = PRIME_W'((64'd1 << e) % 64'(head_prime(HEAD_W'(i))));
    end
    return t;
  endfunction

  // floor(2^RECIP_SHIFT / prime) for every head
  function automatic recip_tab_t recip_tab();
    recip_tab_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(head_prime(HEAD_W'(i))));
    end
    return t;
  endfunction

  localparam prime_tab_t W32_TAB   = pow2_mod_tab(32);
  localparam prime_tab_t W48_TAB   = pow2_mod_tab(48);
  localparam recip_tab_t RECIP_TAB = recip_tab();

endpackage

### rtl/core/ngh_front.sv
// front end: token intake, history selection and segment tracking
module ngh_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           token_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic signed [31:0]           end_token_i,
  input  logic                         full_i,
  output logic                         push_o,
  output ngh_pkg::entry_t              entry_o
);

  logic signed [31:0] end_token_q, prior_q, older_q;
  logic [1:0]         count_q, count_d;

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign cfg_ready_o = 1'b1;

  assign entry_o.cur = token_i;
  assign entry_o.h1  = (count_q >= 2'd1) ? prior_q : end_token_q;
  assign entry_o.h2  = (count_q >= 2'd2) ? older_q : end_token_q;

  always_comb begin
    if (token_i == end_token_q) begin
      count_d = 2'd0;
    end else if (count_q < 2'd2) begin
      count_d = count_q + 2'd1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_token_q <= '0;
      prior_q     <= '0;
      older_q     <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        end_token_q <= end_token_i;
      end
      if (push_o) begin
        older_q <= prior_q;
        prior_q <= token_i;
        count_q <= count_d;
      end
    end
  end

endmodule

### rtl/core/ngh_fifo.sv
// short queue of classified tokens between front and back
module ngh_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ngh_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ngh_pkg::entry_t data_o
);

  localparam int Depth = ngh_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ngh_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/ngh_back.sv
// back end: hash products over two stages and per-head issue
module ngh_back #(
  parameter int HEADS        = 16,
  parameter int BIGRAM_HEADS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  ngh_pkg::entry_t   fifo_data_i,
  output logic              pop_o,
  input  logic              en_i,
  output logic              req_valid_o,
  output ngh_pkg::mod_req_t req_o
);

  logic signed [64:0] uni_lo, bi_lo, tri_lo;
  logic signed [45:0] uni_hi, bi_hi, tri_hi;

  logic [63:0] uni_lo_q, bi_lo_q, tri_lo_q;
  logic [31:0] uni_hi_q, bi_hi_q, tri_hi_q;
  logic        p1_valid_q;

  logic [63:0] uni_p, bi_p, tri_p;
  logic [63:0] bi_q, tri_q;
  logic        h2_valid_q;
  logic [ngh_pkg::HEAD_W-1:0] head_q;

  logic issue, last_issue, h2_load, p1_load;

  // signed token times unsigned constant pieces
  assign uni_lo = fifo_data_i.cur * $signed({1'b0, ngh_pkg::UNI_LO});
  assign bi_lo  = fifo_data_i.h1  * $signed({1'b0, ngh_pkg::BI_LO});
  assign tri_lo = fifo_data_i.h2  * $signed({1'b0, ngh_pkg::TRI_LO});
  assign uni_hi = fifo_data_i.cur * $signed({1'b0, ngh_pkg::UNI_HI});
  assign bi_hi  = fifo_data_i.h1  * $signed({1'b0, ngh_pkg::BI_HI});
  assign tri_hi = fifo_data_i.h2  * $signed({1'b0, ngh_pkg::TRI_HI});

  assign uni_p = uni_lo_q + {uni_hi_q, 32'b0};
  assign bi_p  = bi_lo_q  + {bi_hi_q, 32'b0};
  assign tri_p = tri_lo_q + {tri_hi_q, 32'b0};

  assign issue      = h2_valid_q && en_i;
  assign last_issue = issue && (head_q == ngh_pkg::HEAD_W'(HEADS - 1));
  assign h2_load    = p1_valid_q && (!h2_valid_q || last_issue);
  assign p1_load    = fifo_valid_i && (!p1_valid_q || h2_load);
  assign pop_o      = p1_load;

  assign req_valid_o = h2_valid_q;
  assign req_o.hash  = (head_q < ngh_pkg::HEAD_W'(BIGRAM_HEADS)) ? bi_q : tri_q;
  assign req_o.head  = head_q;
  assign req_o.last  = (head_q == ngh_pkg::HEAD_W'(HEADS - 1));

  always_ff @(posedge clk_i) begin
    if (p1_load) begin
      uni_lo_q <= uni_lo[63:0];
      bi_lo_q  <= bi_lo[63:0];
      tri_lo_q <= tri_lo[63:0];
      uni_hi_q <= uni_hi[31:0];
      bi_hi_q  <= bi_hi[31:0];
      tri_hi_q <= tri_hi[31:0];
    end
    if (h2_load) begin
      bi_q  <= uni_p ^ bi_p;
      tri_q <= uni_p ^ bi_p ^ tri_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      h2_valid_q <= 1'b0;
      head_q     <= '0;
    end else begin
      if (p1_load) begin
        p1_valid_q <= 1'b1;
      end else if (h2_load) begin
        p1_valid_q <= 1'b0;
      end
      if (h2_load) begin
        h2_valid_q <= 1'b1;
      end else if (last_issue) begin
        h2_valid_q <= 1'b0;
      end
      if (last_issue) begin
        head_q <= '0;
      end else if (issue) begin
        head_q <= head_q + ngh_pkg::HEAD_W'(1);
      end
    end
  end

endmodule

### rtl/core/ngh_mod.sv
// pipelined signed remainder by head prime: residue folding, reciprocal quotient, offset
module ngh_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  ngh_pkg::mod_req_t           req_i,
  output logic                        en_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ngh_pkg::HEAD_W-1:0]  head_o,
  output logic [ngh_pkg::ROW_W-1:0]   row_id_o,
  output logic                        last_o
);

  localparam int Bits   = ngh_pkg::HASH_W;
  localparam int PW     = ngh_pkg::PRIME_W;
  localparam int RW     = ngh_pkg::ROW_W;
  localparam int Stages = 7;
  localparam int SumW   = 43;
  localparam int FoldW  = 37;
  localparam int RedW   = 33;
  localparam int QuotW  = 9;
  localparam int RemW   = 26;

  // per-stage side info, index 0 lines up with the magnitude register
  logic [Stages-1:0]          v_q, neg_q, last_sr_q;
  logic [ngh_pkg::HEAD_W-1:0] head_sr_q [Stages];

  logic [Bits-1:0]  mag_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [FoldW-1:0] fold_q, fold_d;
  logic [RedW-1:0]  red_q, red_d, red2_q;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [RemW-1:0]  rem_raw_q, rem_raw_d;
  logic [PW-1:0]    rem_q, rem_d;

  logic [40:0] sum_p1, sum_p2;
  logic [35:0] fold_p;
  logic [29:0] red_p;
  logic [48:0] quot_p;
  logic [33:0] rem_p;

  logic [PW-1:0]               w32_a, w48_a, w32_b, w32_c, p_e, p_f;
  logic [ngh_pkg::RECIP_W-1:0] recip;

  logic                       out_valid_q;
  logic [ngh_pkg::HEAD_W-1:0] head_q;
  logic [ngh_pkg::ROW_W-1:0]  row_q;
  logic                       last_q;

  logic          neg_in;
  logic [PW-1:0] fin_p, fin_fix;

  assign en_o   = !out_valid_q || out_ready_i;
  assign neg_in = req_i.hash[Bits-1];

  // fold bits 32..63 back in with the 2^32 and 2^48 residues
  assign w32_a  = ngh_pkg::W32_TAB[head_sr_q[0]];
  assign w48_a  = ngh_pkg::W48_TAB[head_sr_q[0]];
  assign sum_p1 = 41'(mag_q[47:32]) * 41'(w32_a);
  assign sum_p2 = 41'(mag_q[63:48]) * 41'(w48_a);
  assign sum_d  = SumW'(mag_q[31:0]) + SumW'(sum_p1) + SumW'(sum_p2);

  // second and third fold down to 33 bits
  assign w32_b  = ngh_pkg::W32_TAB[head_sr_q[1]];
  assign fold_p = 36'(sum_q[SumW-1:32]) * 36'(w32_b);
  assign fold_d = FoldW'(sum_q[31:0]) + FoldW'(fold_p);

  assign w32_c  = ngh_pkg::W32_TAB[head_sr_q[2]];
  assign red_p  = 30'(fold_q[FoldW-1:32]) * 30'(w32_c);
  assign red_d  = RedW'(fold_q[31:0]) + RedW'(red_p);

  // quotient estimate is exact or one low
  assign recip  = ngh_pkg::RECIP_TAB[head_sr_q[3]];
  assign quot_p = 49'(red_q) * 49'(recip);
  assign quot_d = quot_p[ngh_pkg::RECIP_SHIFT +: QuotW];

  // raw remainder below twice the prime
  assign p_e       = ngh_pkg::head_prime(head_sr_q[4]);
  assign rem_p     = 34'(quot_q) * 34'(p_e);
  assign rem_raw_d = red2_q[RemW-1:0] - rem_p[RemW-1:0];

  assign p_f   = ngh_pkg::head_prime(head_sr_q[5]);
  assign rem_d = (rem_raw_q >= RemW'(p_f)) ? PW'(rem_raw_q - RemW'(p_f)) : rem_raw_q[PW-1:0];

  // negative hashes fold back to the non-negative remainder
  assign fin_p   = ngh_pkg::head_prime(head_sr_q[Stages-1]);
  assign fin_fix = (neg_q[Stages-1] && (rem_q != '0)) ? fin_p - rem_q : rem_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      mag_q     <= neg_in ? (~req_i.hash + Bits'(1)) : req_i.hash;
      sum_q     <= sum_d;
      fold_q    <= fold_d;
      red_q     <= red_d;
      quot_q    <= quot_d;
      red2_q    <= red_q;
      rem_raw_q <= rem_raw_d;
      rem_q     <= rem_d;
      neg_q     <= {neg_q[Stages-2:0], neg_in};
      last_sr_q <= {last_sr_q[Stages-2:0], req_i.last};
      head_sr_q[0] <= req_i.head;
      for (int k = 1; k < Stages; k++) begin
        head_sr_q[k] <= head_sr_q[k-1];
      end
      head_q <= head_sr_q[Stages-1];
      row_q  <= ngh_pkg::head_base(head_sr_q[Stages-1]) + RW'(fin_fix);
      last_q <= last_sr_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      v_q         <= {v_q[Stages-2:0], req_valid_i};
      out_valid_q <= v_q[Stages-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign head_o      = head_q;
  assign row_id_o    = row_q;
  assign last_o      = last_q;

endmodule

### rtl/core/ngram_hash_row_ids.sv
// top level of the n-gram hash row id generator
// usage:
//   input channel (in_valid_i / in_ready_o / token_i): one signed token per word
//   config channel (cfg_valid_i / cfg_ready_o / end_token_i): sets the end token,
//     always ready, write only while the block is idle
//   output channel (out_valid_o / out_ready_i): HEADS words per token, in head
//     order, each with head_o, row_id_o and last_o on the final head
// the head issuer in the back end feeds one head per cycle into the remainder
//   pipeline while it is not stalled, and loads the next token's products meanwhile
// path from an accepted token to its first word: queue, two product stages, a
//   magnitude stage, six remainder stages, output register
// the front end keeps taking tokens into a two-entry queue while the back end
//   works, so intake only stalls once the queue is full
// a stalled receiver freezes the remainder pipeline in place; nothing is lost
// reset clears history, segment count and end token to zero and empties all
//   pipeline and queue valid bits
module ngram_hash_row_ids #(
  parameter int HEADS        = 16,
  parameter int BIGRAM_HEADS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          token_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic signed [31:0]          end_token_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ngh_pkg::HEAD_W-1:0]  head_o,
  output logic [ngh_pkg::ROW_W-1:0]   row_id_o,
  output logic                        last_o
);

  // front to queue
  logic            push, full;
  ngh_pkg::entry_t entry;

  // queue to back end
  logic            fifo_valid, pop;
  ngh_pkg::entry_t fifo_data;

  // back end to remainder pipeline
  logic              req_valid, en;
  ngh_pkg::mod_req_t req;

  ngh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .token_i     (token_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .end_token_i (end_token_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  ngh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  ngh_back #(
    .HEADS        (HEADS),
    .BIGRAM_HEADS (BIGRAM_HEADS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .en_i         (en),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  ngh_mod u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head_o),
    .row_id_o    (row_id_o),
    .last_o      (last_o)
  );

endmodule

### dv/ngram_hash_row_ids_test.sv
// n-gram hash row id testbench: directed and random tokens, checked row ids per head
`timescale 1ns / 1ps

module ngram_hash_row_ids_test;

  localparam int NUM_HEADS  = 16;
  localparam int BI_HEADS   = 8;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 120;
  localparam int CFG_END_TOKEN = 0;  // the only register

  typedef struct packed {
    logic [ngh_pkg::HEAD_W-1:0] head;
    logic [ngh_pkg::ROW_W-1:0]  row_id;
    logic                       last;
  } row_word_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [31:0]         token_i = '0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic signed [31:0]         end_token_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [ngh_pkg::HEAD_W-1:0] head_o;
  logic [ngh_pkg::ROW_W-1:0]  row_id_o;
  logic                       last_o;

  // head tables: prime per head and start of the head's slice of the table
  logic [31:0] prime_tab [NUM_HEADS] = '{
    20000003, 20000023, 20000033, 20000047, 20000059, 20000063, 20000069, 20000077,
    20000081, 20000093, 20000107, 20000147, 20000153, 20000159, 20000161, 20000171};
  logic [31:0] base_tab [NUM_HEADS] = '{
    0, 20000003, 40000026, 60000059, 80000106, 100000165, 120000228, 140000297,
    160000374, 180000455, 200000548, 220000655, 240000802, 260000955, 280001114,
    300001275};

  // predictor copy of the block's history and register
  logic [31:0] cur_end_token = '0;
  logic [31:0] prev_tok = '0;
  logic [31:0] prev2_tok = '0;
  logic [1:0]  seg_pos = '0;

  logic [31:0] token_queue [$];
  row_word_t   row_queue [$];
  bit          calm = 1'b0;
  bit          failed = 1'b0;
  bit          in_taken = 1'b0;
  int          cycles = 0;
  int          tokens_sent = 0;
  int          words_checked = 0;
  int          end_hits = 0;

  ngram_hash_row_ids #(
    .HEADS       (NUM_HEADS),
    .BIGRAM_HEADS(BI_HEADS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .token_i    (token_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .end_token_i(end_token_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head_o),
    .row_id_o   (row_id_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // token times constant, mod 2^64, after sign extension
  function automatic logic [63:0] tok_product(logic [31:0] t, logic [63:0] k);
    logic [63:0] wide;
    wide = {{32{t[31]}}, t};
    return wide * k;
  endfunction

  // non-negative remainder of a signed 64-bit hash
  function automatic logic [31:0] hash_remainder(logic [63:0] hash, logic [31:0] p);
    longint unsigned mag;
    longint unsigned r;
    if (hash[63]) begin
      mag = ~hash + 64'd1;   // exact for the most negative value too
      r = mag % p;
      return (r == 0) ? 32'd0 : p - 32'(r);
    end
    return 32'(hash % p);
  endfunction

  // expected words for one accepted token, then history update
  task automatic predict_row_ids(logic [31:0] tok);
    logic [31:0] hist1;
    logic [31:0] hist2;
    logic [63:0] bi_hash;
    logic [63:0] tri_hash;
    row_word_t   w;
    hist1 = (seg_pos >= 1) ? prev_tok : cur_end_token;
    hist2 = (seg_pos >= 2) ? prev2_tok : cur_end_token;
    bi_hash = tok_product(tok, ngh_pkg::MUL_UNI) ^ tok_product(hist1, ngh_pkg::MUL_BI);
    tri_hash = bi_hash ^ tok_product(hist2, ngh_pkg::MUL_TRI);
    for (int h = 0; h < NUM_HEADS; h++) begin
      w.head = ngh_pkg::HEAD_W'(h);
      w.row_id = ngh_pkg::ROW_W'(base_tab[h] +
          hash_remainder((h < BI_HEADS) ? bi_hash : tri_hash, prime_tab[h]));
      w.last = (h == NUM_HEADS - 1);
      row_queue.push_back(w);
    end
    prev2_tok = prev_tok;
    prev_tok = tok;
    if (tok == cur_end_token) begin
      seg_pos = 2'd0;
      end_hits++;
    end else if (seg_pos < 2) begin
      seg_pos = seg_pos + 2'd1;
    end
  endtask

  // token driver: holds a word until taken, else pulls the next pending token
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (token_queue.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
        in_valid_i <= 1'b1;
        token_i <= token_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && (calm || $urandom_range(99) >= 21);
  end

  // monitor: intake prediction and result check at the rising edge
  always @(posedge clk_i) begin
    row_word_t want;
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) begin
      predict_row_ids(token_i);
      tokens_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (row_queue.size() == 0) begin
        $error("unexpected word: head %0d row_id %0d last %0b", head_o, row_id_o, last_o);
        failed = 1'b1;
      end else begin
        want = row_queue.pop_front();
        words_checked++;
        if (head_o !== want.head) begin
          $error("head: expected %0d, got %0d", want.head, head_o);
          failed = 1'b1;
        end
        if (row_id_o !== want.row_id) begin
          $error("row_id: expected %0d, got %0d", want.row_id, row_id_o);
          failed = 1'b1;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          failed = 1'b1;
        end
      end
    end
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, row_queue.size());
      $display("** ngram_hash_row_ids: FAILED **");
      $finish;
    end
  end

  // wait until every token is in and every word is out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (token_queue.size() != 0 || in_valid_i || row_queue.size() != 0);
  endtask

  task automatic write_end_token(logic [31:0] value);
    bit done;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    end_token_i <= value;
    do begin
      @(posedge clk_i);
      done = cfg_valid_i && cfg_ready_o;
    end while (!done);
    cur_end_token = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly runs of real tokens with the end token mixed in, some narrow values
  task automatic queue_random(int count, int end_rate);
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       t = $urandom_range(255);
        1:       t = -$urandom_range(255);
        2:       t = {1'($urandom_range(1)),
                      ($urandom_range(1) != 0) ? 31'h7FFF_FFFF : 31'h0};
        default: t = $urandom;
      endcase
      if ($urandom_range(99) < end_rate) t = cur_end_token;
      token_queue.push_back(t);
    end
  endtask

  initial begin
    logic [31:0] ends [4];
    ends = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, history fill after reset and after end tokens
    write_end_token(32'h0);
    token_queue = '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h1, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h1234_5678};
    wait_idle();
    write_end_token(32'h8000_0000);
    token_queue = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h0};
    wait_idle();

    // random phases over several end tokens, one phase without any idling
    foreach (ends[i]) begin
      write_end_token(ends[i]);
      calm = (i == 1);
      queue_random(18, (i == 3) ? 25 : 10);
      wait_idle();
    end
    calm = 1'b0;
    write_end_token($urandom);
    queue_random(15, 15);
    wait_idle();

    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("covered %0d tokens (%0d end tokens), %0d row words checked over 7 settings",
             tokens_sent, end_hits, words_checked);
    if (!failed && row_queue.size() == 0) begin
      $display("** ngram_hash_row_ids: PASSED **");
    end else begin
      $display("** ngram_hash_row_ids: FAILED **");
    end
    $finish;
  end

endmodule
